// ----- src/plswf_pkg.sv -----
// ============================================================================
// plswf_pkg
// Shared sizes, item codes and memory port bundles for the palette lookup
// and shadow write filter.
// ============================================================================
package plswf_pkg;

  // Sizes of the design.
  localparam int BANK_COUNT   = 14;
  localparam int OUT_BYTES    = 16000;
  localparam int DECIMATION   = 4;
  localparam int SHADOW_DEPTH = 16384;

  localparam int BANK_SIZE  = 256;
  localparam int TABLE_SIZE = BANK_COUNT * BANK_SIZE;

  // Field widths of the stream items.
  localparam int KIND_W   = 2;
  localparam int TIDX_W   = 12;
  localparam int COLOR_W  = 4;
  localparam int PIXEL_W  = 8;
  localparam int BANK_W   = 4;
  localparam int OFFSET_W = 14;

  // Beat widths, padded to whole bytes.
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  // Derived address and counter widths.
  localparam int TBL_AW = $clog2(TABLE_SIZE);
  localparam int SH_AW  = $clog2(SHADOW_DEPTH);
  localparam int PH_W   = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;

  // Item kinds carried in tuser.
  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD    = 2'd0,
    KIND_PIXEL   = 2'd1,
    KIND_RESTART = 2'd2
  } kind_t;

  // Color table write request.
  typedef struct packed {
    logic              en;
    logic [TIDX_W-1:0] index;
    logic [COLOR_W-1:0] color;
  } tbl_load_t;

  // Color table lookup request.
  typedef struct packed {
    logic               en;
    logic [BANK_W-1:0]  bank;
    logic [PIXEL_W-1:0] pixel;
  } tbl_lookup_t;

  // Shadow memory read request.
  typedef struct packed {
    logic             en;
    logic [SH_AW-1:0] addr;
  } sh_rd_t;

  // Shadow memory write request.
  typedef struct packed {
    logic               en;
    logic [SH_AW-1:0]   addr;
    logic [COLOR_W-1:0] color;
  } sh_wr_t;

endpackage

// ----- src/plswf_table.sv -----
// ============================================================================
// plswf_table
// Banked color table: one write port for table loads and one registered
// read port that maps a pixel through the selected bank.
// ============================================================================
module plswf_table (
  input  logic                           clk,
  input  plswf_pkg::tbl_load_t           load,
  input  plswf_pkg::tbl_lookup_t         lookup,
  output logic [plswf_pkg::COLOR_W-1:0]  color
);

  logic [plswf_pkg::COLOR_W-1:0] mem [plswf_pkg::TABLE_SIZE];
  logic [plswf_pkg::BANK_W-1:0]  bank_sat;
  logic [plswf_pkg::TBL_AW-1:0]  rd_addr;
  logic [plswf_pkg::TBL_AW-1:0]  wr_addr;
  logic                          wr_en;

  // A bank past the last one saturates to the last bank.
  always_comb begin
    if (32'(lookup.bank) >= plswf_pkg::BANK_COUNT) begin
      bank_sat = plswf_pkg::BANK_W'(plswf_pkg::BANK_COUNT - 1);
    end else begin
      bank_sat = lookup.bank;
    end
    rd_addr = plswf_pkg::TBL_AW'({bank_sat, lookup.pixel});
    wr_addr = plswf_pkg::TBL_AW'(load.index);
    // Loads beyond the last bank are dropped.
    wr_en   = load.en && (32'(load.index) < plswf_pkg::TABLE_SIZE);
  end

  // Table write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= load.color;
    end
  end

  // Registered read port; data holds between lookups.
  always_ff @(posedge clk) begin
    if (lookup.en) begin
      color <= mem[rd_addr];
    end
  end

endmodule

// ----- src/plswf_shadow.sv -----
// ============================================================================
// plswf_shadow
// Shadow copy of display memory: clearing pass after reset, registered read
// port and write-to-read forwarding for a read issued at the same edge as a
// write to the same entry.
// ============================================================================
module plswf_shadow (
  input  logic                           clk,
  input  logic                           rst,
  input  plswf_pkg::sh_rd_t              rd,
  input  plswf_pkg::sh_wr_t              wr,
  output logic [plswf_pkg::COLOR_W-1:0]  rd_color,
  output logic                           clearing
);

  logic [plswf_pkg::COLOR_W-1:0] mem [plswf_pkg::SHADOW_DEPTH];
  logic [plswf_pkg::SH_AW-1:0]   clr_addr;
  logic [plswf_pkg::COLOR_W-1:0] mem_q;
  logic [plswf_pkg::COLOR_W-1:0] fwd_color;
  logic                          fwd_hit;
  logic                          mem_we;
  logic [plswf_pkg::SH_AW-1:0]   mem_waddr;
  logic [plswf_pkg::COLOR_W-1:0] mem_wdata;

  // Clearing pass: one entry per cycle from reset until the last entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == plswf_pkg::SH_AW'(plswf_pkg::SHADOW_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // The clearing pass owns the write port until it ends.
  always_comb begin
    if (clearing) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else begin
      mem_we    = wr.en;
      mem_waddr = wr.addr;
      mem_wdata = wr.color;
    end
  end

  // Memory write port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // Memory read port; the array returns the old entry on a collision.
  always_ff @(posedge clk) begin
    if (rd.en) begin
      mem_q <= mem[rd.addr];
    end
  end

  // Capture a same-edge write to the entry being read.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (rd.en) begin
      fwd_hit <= wr.en && (wr.addr == rd.addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      fwd_color <= wr.color;
    end
  end

  assign rd_color = fwd_hit ? fwd_color : mem_q;

endmodule

// ----- src/palette_lut_shadow_write_filter_top.sv -----
// ============================================================================
// palette_lut_shadow_write_filter_top
// Decimates an indexed pixel stream, maps kept pixels through a banked color
// table and emits a display write only where the shadow copy differs.
// ============================================================================
//
//  Channel  | Direction | Beat contents
//  ---------+-----------+----------------------------------------------------
//  s_axis   | in        | tuser: kind; tdata: table_index, table_color, pixel
//  m_axis   | out       | tdata: display_offset, color
//  cfg      | in        | palette_select, written when cfg_we is high
//
//  One item is accepted per cycle unless clearing or a blocked compare stage
//  holds input off; a kept pixel's table and shadow reads are registered at
//  the accepting edge, then the compare stage loads any result into the output register.
//  After reset the shadow memory clears one entry per cycle; input waits for
//  all SHADOW_DEPTH (16384) entries; cfg writes are taken anyway.
//  A result waiting in the output register stalls input only when the item
//  in the compare stage also has a result to deliver.
//
module palette_lut_shadow_write_filter_top (
  input  logic                               clk,
  input  logic                               rst,
  // Input stream.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [11:0] table_index, [15:12] table_color, [23:16] pixel
  input  logic [plswf_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // [1:0] kind
  input  logic [plswf_pkg::KIND_W-1:0]       s_axis_tuser,
  // Output stream.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [13:0] display_offset, [17:14] color, [23:18] zero
  output logic [plswf_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // Configuration.
  input  logic                               cfg_we,
  input  logic [plswf_pkg::BANK_W-1:0]       cfg_wdata
);

  logic [plswf_pkg::BANK_W-1:0]   palette_select;
  logic [plswf_pkg::PH_W-1:0]     phase;
  logic [plswf_pkg::OFFSET_W-1:0] offset;

  logic                           accept;
  logic                           is_load;
  logic                           is_pixel;
  logic                           is_restart;
  logic                           keep;
  logic [plswf_pkg::TIDX_W-1:0]   in_tidx;
  logic [plswf_pkg::COLOR_W-1:0]  in_tcolor;
  logic [plswf_pkg::PIXEL_W-1:0]  in_pixel;

  logic                           p1_valid;
  logic [plswf_pkg::OFFSET_W-1:0] p1_offset;
  logic                           p1_inrange;
  logic                           p1_hit;
  logic                           p1_adv;

  logic [plswf_pkg::COLOR_W-1:0]  tbl_color;
  logic [plswf_pkg::COLOR_W-1:0]  sh_color;
  logic                           clearing;

  plswf_pkg::tbl_load_t   tbl_load;
  plswf_pkg::tbl_lookup_t tbl_lookup;
  plswf_pkg::sh_rd_t      sh_rd;
  plswf_pkg::sh_wr_t      sh_wr;

  // Input beat decode.
  always_comb begin
    in_tidx    = s_axis_tdata[11:0];
    in_tcolor  = s_axis_tdata[15:12];
    in_pixel   = s_axis_tdata[23:16];
    accept     = s_axis_tvalid && s_axis_tready;
    is_load    = (s_axis_tuser == plswf_pkg::KIND_LOAD);
    is_pixel   = (s_axis_tuser == plswf_pkg::KIND_PIXEL);
    is_restart = (s_axis_tuser == plswf_pkg::KIND_RESTART);
    keep       = (phase == '0);
  end

  // Palette bank register.
  always_ff @(posedge clk) begin
    if (rst) begin
      palette_select <= '0;
    end else if (cfg_we) begin
      palette_select <= cfg_wdata;
    end
  end

  // Frame position kept as phase within a group and display offset.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= '0;
      offset <= '0;
    end else if (accept && is_restart) begin
      phase  <= '0;
      offset <= '0;
    end else if (accept && is_pixel) begin
      if (phase == plswf_pkg::PH_W'(plswf_pkg::DECIMATION - 1)) begin
        phase <= '0;
        if (offset == plswf_pkg::OFFSET_W'(plswf_pkg::OUT_BYTES - 1)) begin
          offset <= '0;
        end else begin
          offset <= offset + 1'b1;
        end
      end else begin
        phase <= phase + 1'b1;
      end
    end
  end

  // Memory requests for the accepted beat.
  always_comb begin
    tbl_load.en     = accept && is_load;
    tbl_load.index  = in_tidx;
    tbl_load.color  = in_tcolor;
    tbl_lookup.en   = accept && is_pixel && keep;
    tbl_lookup.bank = palette_select;
    tbl_lookup.pixel = in_pixel;
    sh_rd.en        = accept && is_pixel && keep;
    sh_rd.addr      = plswf_pkg::SH_AW'(offset);
  end

  plswf_table u_table (
    .clk    (clk),
    .load   (tbl_load),
    .lookup (tbl_lookup),
    .color  (tbl_color)
  );

  plswf_shadow u_shadow (
    .clk      (clk),
    .rst      (rst),
    .rd       (sh_rd),
    .wr       (sh_wr),
    .rd_color (sh_color),
    .clearing (clearing)
  );

  // Compare stage: emit when the color changes or the offset has no shadow.
  always_comb begin
    p1_hit        = p1_valid && (!p1_inrange || (sh_color != tbl_color));
    p1_adv        = !p1_hit || !m_axis_tvalid || m_axis_tready;
    s_axis_tready = !clearing && (!p1_valid || p1_adv);
    sh_wr.en      = p1_hit && p1_adv && p1_inrange;
    sh_wr.addr    = plswf_pkg::SH_AW'(p1_offset);
    sh_wr.color   = tbl_color;
  end

  // Compare stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (!p1_valid || p1_adv) begin
      p1_valid <= accept && is_pixel && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_offset  <= offset;
      p1_inrange <= (32'(offset) < plswf_pkg::SHADOW_DEPTH);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (p1_hit && p1_adv) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_hit && p1_adv) begin
      m_axis_tdata <= plswf_pkg::OUT_DATA_W'({tbl_color, p1_offset});
    end
  end

  // Checks on the pipeline control.
  a_no_input_while_clearing : assert property (
    @(posedge clk) disable iff (rst) clearing |-> !s_axis_tready
  ) else $error("input taken during shadow clearing pass");

  a_stall_blocks_input : assert property (
    @(posedge clk) disable iff (rst)
      (p1_hit && m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready
  ) else $error("input taken while compare stage is blocked");

  a_kept_pixel_enters_stage : assert property (
    @(posedge clk) disable iff (rst)
      (accept && is_pixel && keep) |=> p1_valid
  ) else $error("kept pixel did not enter compare stage");

  a_result_lands_in_output : assert property (
    @(posedge clk) disable iff (rst) (p1_hit && p1_adv) |=> m_axis_tvalid
  ) else $error("result lost between compare stage and output");

endmodule

// ----- sim/tb_palette_lut_shadow_write_filter_top.sv -----
// ============================================================================
// tb_palette_lut_shadow_write_filter_top
// Self-checking bench for the palette lookup and shadow write filter. A
// queue-fed driver sends table loads, pixels, restarts and unknown kinds.
// A predictor tracks the color table, shadow memory and frame position to
// work out each display write. A monitor checks every output beat in order.
// ============================================================================
`timescale 1ns / 1ps

module tb_palette_lut_shadow_write_filter_top;

  localparam int FRAME_PIXELS   = plswf_pkg::OUT_BYTES * plswf_pkg::DECIMATION;
  localparam int STALL_PCT      = 23;
  localparam int LAT_CYCLES     = 4;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS    = 50;
  localparam int STEADY_ITEMS   = 64;
  localparam int BANK_SEED_LDS  = 14;
  localparam int NUM_PHASES     = 7;
  // Palette selects per phase, lowest nibble first; 14 and 15 saturate.
  localparam logic [4*NUM_PHASES-1:0] PALETTE_PLAN =
    {4'd3, 4'd9, 4'd13, 4'd6, 4'd14, 4'd0, 4'd15};
  // The fourth tuser code has no meaning and must be dropped.
  localparam logic [plswf_pkg::KIND_W-1:0] KIND_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [plswf_pkg::KIND_W-1:0]  kind;
    logic [plswf_pkg::TIDX_W-1:0]  tidx;
    logic [plswf_pkg::COLOR_W-1:0] tcol;
    logic [plswf_pkg::PIXEL_W-1:0] pixel;
  } stream_item_t;

  typedef struct packed {
    logic [plswf_pkg::OFFSET_W-1:0] offset;
    logic [plswf_pkg::COLOR_W-1:0]  color;
  } display_write_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [plswf_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
  logic [plswf_pkg::KIND_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [plswf_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic cfg_we = 1'b0;
  logic [plswf_pkg::BANK_W-1:0] cfg_wdata = '0;

  // Stimulus and expectation stores.
  stream_item_t   source_items[$];
  display_write_t pending_writes[$];
  stream_item_t   cur_item;
  bit             in_beat_done = 1'b0;

  // Predictor state.
  logic [plswf_pkg::COLOR_W-1:0] lut_color [plswf_pkg::TABLE_SIZE];
  logic [plswf_pkg::COLOR_W-1:0] shadow_color [plswf_pkg::SHADOW_DEPTH];
  bit                 gen_loaded [plswf_pkg::TABLE_SIZE];
  int unsigned        pixel_pos = 0;
  int                 active_bank = 0;

  // Flow control knobs.
  bit steady_stream = 1'b0;
  int rx_hold_left = 0;

  int fail_count = 0;
  int n_writes = 0, n_loads = 0, n_pixels = 0, n_restarts = 0, n_ignored = 0;

  palette_lut_shadow_write_filter_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one accepted beat to the mirrored state and record any display write.
  task automatic predict_display_write(input stream_item_t it);
    int unsigned    offset;
    logic [plswf_pkg::COLOR_W-1:0] c;
    display_write_t w;
    case (it.kind)
      plswf_pkg::KIND_LOAD: begin
        n_loads++;
        if (it.tidx < plswf_pkg::TABLE_SIZE) lut_color[it.tidx] = it.tcol;
      end
      plswf_pkg::KIND_RESTART: begin
        n_restarts++;
        pixel_pos = 0;
      end
      plswf_pkg::KIND_PIXEL: begin
        n_pixels++;
        if (pixel_pos % plswf_pkg::DECIMATION == 0) begin
          offset = pixel_pos / plswf_pkg::DECIMATION;
          c = lut_color[active_bank * plswf_pkg::BANK_SIZE + it.pixel];
          w.offset = offset[plswf_pkg::OFFSET_W-1:0];
          w.color = c;
          if (offset >= plswf_pkg::SHADOW_DEPTH) begin
            pending_writes.push_back(w);
          end else if (shadow_color[offset] != c) begin
            shadow_color[offset] = c;
            pending_writes.push_back(w);
          end
        end
        pixel_pos++;
        if (pixel_pos >= FRAME_PIXELS) begin
          pixel_pos = 0;
        end
      end
      default: n_ignored++;
    endcase
  endtask

  // Input driver: a beat stays up until taken, then the next one may follow.
  always @(negedge clk) begin
    if (!rst && (!s_axis_tvalid || in_beat_done)) begin
      in_beat_done = 1'b0;
      if (source_items.size() != 0 &&
          (steady_stream || $urandom_range(99) >= STALL_PCT)) begin
        cur_item = source_items.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {cur_item.pixel, cur_item.tcol, cur_item.tidx};
        s_axis_tuser <= cur_item.kind;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Accepted input beats feed the predictor.
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      predict_display_write(cur_item);
      in_beat_done = 1'b1;
    end
  end

  // Output ready: random stalls, plus a counted hold-off when requested.
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      m_axis_tready <= 1'b0;
      rx_hold_left--;
    end else begin
      m_axis_tready <= steady_stream || ($urandom_range(99) >= STALL_PCT);
    end
  end

  // Monitor: compare each display write with the oldest expectation.
  always @(posedge clk) begin : check_display_writes
    display_write_t w;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_writes.size() == 0) begin
        $error("display write with none expected: offset %0d color %0d",
               m_axis_tdata[plswf_pkg::OFFSET_W-1:0],
               m_axis_tdata[plswf_pkg::OFFSET_W +: plswf_pkg::COLOR_W]);
        fail_count++;
      end else begin
        w = pending_writes.pop_front();
        n_writes++;
        if (m_axis_tdata[plswf_pkg::OFFSET_W-1:0] !== w.offset) begin
          $error("display_offset: expected %0d, actual %0d",
                 w.offset, m_axis_tdata[plswf_pkg::OFFSET_W-1:0]);
          fail_count++;
        end
        if (m_axis_tdata[plswf_pkg::OFFSET_W +: plswf_pkg::COLOR_W] !== w.color) begin
          $error("color: expected %0d, actual %0d",
                 w.color, m_axis_tdata[plswf_pkg::OFFSET_W +: plswf_pkg::COLOR_W]);
          fail_count++;
        end
        if (m_axis_tdata[plswf_pkg::OUT_DATA_W-1:plswf_pkg::OFFSET_W+plswf_pkg::COLOR_W]
            !== '0) begin
          $error("tdata padding: expected 0, actual %0h",
                 m_axis_tdata[plswf_pkg::OUT_DATA_W-1:
                              plswf_pkg::OFFSET_W+plswf_pkg::COLOR_W]);
          fail_count++;
        end
      end
    end
  end

  // Queue one item and remember which table entries will hold a color.
  task automatic push_item(input int kind, input int unsigned tidx,
                           input int unsigned tcol, input int unsigned pix);
    stream_item_t it;
    it.kind = plswf_pkg::KIND_W'(kind);
    it.tidx = plswf_pkg::TIDX_W'(tidx);
    it.tcol = plswf_pkg::COLOR_W'(tcol);
    it.pixel = plswf_pkg::PIXEL_W'(pix);
    if (it.kind == plswf_pkg::KIND_LOAD && it.tidx < plswf_pkg::TABLE_SIZE)
      gen_loaded[it.tidx] = 1'b1;
    source_items.push_back(it);
  endtask

  // Pixels only ever hit table entries that have been loaded.
  function automatic int unsigned pick_loaded_pixel();
    int unsigned p;
    do p = $urandom_range(255);
    while (!gen_loaded[active_bank * plswf_pkg::BANK_SIZE + p]);
    return p;
  endfunction

  task automatic push_random_item();
    int r;
    int unsigned idx;
    r = $urandom_range(99);
    if (r < 66) begin
      push_item(plswf_pkg::KIND_PIXEL, $urandom, $urandom, pick_loaded_pixel());
    end else if (r < 86) begin
      // Half the loads hit the active bank, the rest anywhere incl. past the table.
      if ($urandom_range(1) != 0)
        idx = active_bank * plswf_pkg::BANK_SIZE + $urandom_range(255);
      else idx = $urandom_range(4095);
      push_item(plswf_pkg::KIND_LOAD, idx, $urandom, $urandom);
    end else if (r < 93) begin
      push_item(plswf_pkg::KIND_RESTART, $urandom, $urandom, $urandom);
    end else begin
      push_item(KIND_UNKNOWN, $urandom, $urandom, $urandom);
    end
  endtask

  // Seed the active bank with its extreme entries and a spread of others.
  task automatic load_active_bank();
    push_item(plswf_pkg::KIND_LOAD, active_bank * plswf_pkg::BANK_SIZE,
              $urandom, $urandom);
    push_item(plswf_pkg::KIND_LOAD, active_bank * plswf_pkg::BANK_SIZE + 255,
              $urandom, $urandom);
    repeat (BANK_SEED_LDS)
      push_item(plswf_pkg::KIND_LOAD,
                active_bank * plswf_pkg::BANK_SIZE + $urandom_range(255),
                $urandom, $urandom);
  endtask

  // Wait until every queued beat went in and every write came out.
  task automatic wait_drained();
    while (source_items.size() != 0 || s_axis_tvalid || pending_writes.size() != 0)
      @(posedge clk);
    repeat (LAT_CYCLES) @(posedge clk);
  endtask

  task automatic set_palette(input logic [plswf_pkg::BANK_W-1:0] sel);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= sel;
    @(negedge clk);
    cfg_we <= 1'b0;
    active_bank = (sel >= plswf_pkg::BANK_COUNT) ? plswf_pkg::BANK_COUNT - 1 : int'(sel);
  endtask

  // Main sequence: reset, directed checks, random phases, a full-rate stretch.
  initial begin
    int ph;
    for (int k = 0; k < plswf_pkg::SHADOW_DEPTH; k++) shadow_color[k] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    set_palette(4'd0);

    // Directed: table extremes, ignored loads, skipped and unchanged pixels.
    push_item(plswf_pkg::KIND_LOAD, 0, 15, 'hFF);
    push_item(plswf_pkg::KIND_LOAD, 255, 9, 0);
    push_item(plswf_pkg::KIND_LOAD, 1, 0, 'hA5);
    push_item(plswf_pkg::KIND_LOAD, plswf_pkg::TABLE_SIZE - 1, 5, 'h5A);
    push_item(plswf_pkg::KIND_LOAD, 'hFFF, 3, 0);
    push_item(plswf_pkg::KIND_LOAD, plswf_pkg::TABLE_SIZE, 12, 'hFF);
    push_item(plswf_pkg::KIND_PIXEL, 'hFFF, 'hF, 0);
    push_item(plswf_pkg::KIND_PIXEL, 0, 0, 255);
    push_item(plswf_pkg::KIND_PIXEL, $urandom, $urandom, 0);
    push_item(plswf_pkg::KIND_PIXEL, $urandom, $urandom, 0);
    push_item(plswf_pkg::KIND_PIXEL, $urandom, $urandom, 1);
    push_item(plswf_pkg::KIND_PIXEL, $urandom, $urandom, 255);
    push_item(plswf_pkg::KIND_RESTART, 'hFFF, 'hF, 'hFF);
    push_item(KIND_UNKNOWN, 'hFFF, 'hF, 'hFF);
    push_item(plswf_pkg::KIND_PIXEL, $urandom, $urandom, 0);
    repeat (3) push_item(plswf_pkg::KIND_PIXEL, $urandom, $urandom, 255);
    push_item(plswf_pkg::KIND_PIXEL, $urandom, $urandom, 255);
    wait_drained();

    // Random phases, one palette select each; the third holds the output off.
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      set_palette(PALETTE_PLAN[ph*4 +: 4]);
      push_item(plswf_pkg::KIND_RESTART, $urandom, $urandom, $urandom);
      load_active_bank();
      if (ph == 2) rx_hold_left = RX_HOLD_CYCLES;
      repeat (PHASE_ITEMS) push_random_item();
      wait_drained();
    end

    // A stretch of pixels at full rate with no idling on either side.
    steady_stream = 1'b1;
    push_item(plswf_pkg::KIND_RESTART, $urandom, $urandom, $urandom);
    repeat (STEADY_ITEMS)
      push_item(plswf_pkg::KIND_PIXEL, $urandom, $urandom, pick_loaded_pixel());
    wait_drained();
    steady_stream = 1'b0;
    repeat (2 * LAT_CYCLES) @(posedge clk);

    $display("Checked %0d display writes; beats: %0d loads, %0d pixels, %0d restarts, %0d unknown.",
             n_writes, n_loads, n_pixels, n_restarts, n_ignored);
    $display("Covered several palette selects incl. saturated banks, a long output hold-off.");
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog covering the shadow clearing pass and all traffic.
  initial begin
    #1_000_000;
    $display("Timed out with %0d beats queued and %0d writes outstanding.",
             source_items.size(), pending_writes.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- palette_lut_shadow_write_filter_top.f -----
src/plswf_pkg.sv
src/plswf_table.sv
src/plswf_shadow.sv
src/palette_lut_shadow_write_filter_top.sv
sim/tb_palette_lut_shadow_write_filter_top.sv
